@@ hw/rtl/lower_envelope_line_store_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the lower envelope line store
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef LOWER_ENVELOPE_LINE_STORE_ASSERT_SVH
`define LOWER_ENVELOPE_LINE_STORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication
`define LELS_ASSERT_IMPLY(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define LELS_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LELS_ASSERT_IMPLY(label, clk_s, rst_s, ante, cons, msg)
`define LELS_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg)
`endif

`endif

@@ hw/rtl/lels_pkg.sv @@
// ----------------------------------------------------------------------------
// lels_pkg
// Field widths, stream packing and constants of the lower envelope line store.
// ----------------------------------------------------------------------------
`default_nettype none

package lels_pkg;

  // Default stack depth
  localparam int MAX_LINES_DEF = 1024;

  // Input fields
  localparam int SLOPE_W = 32;
  localparam int ICPT_W  = 48;
  localparam int X_W     = 32;
  localparam int S_TDATA_W = SLOPE_W + ICPT_W + X_W;   // 112, whole bytes

  // Result fields
  localparam int VALUE_W = 64;
  localparam int BEST_W  = 10;
  localparam int LCNT_W  = 11;
  localparam int M_TDATA_W = ((VALUE_W + BEST_W + LCNT_W + 7) / 8) * 8;   // 88

  // One stored line: intercept above slope
  localparam int LINE_W = SLOPE_W + ICPT_W;

  // Multiplier operand width and cross-product accumulator width
  localparam int MUL_W = SLOPE_W + 1;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W = (ICPT_W + 1) + (SLOPE_W + 1);

  // Request kinds
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Value reported by a query on an empty store
  localparam logic [VALUE_W-1:0] EMPTY_VALUE = 64'd10000000000000000;

endpackage

`default_nettype wire

@@ hw/rtl/lower_envelope_line_store.sv @@
// ----------------------------------------------------------------------------
// lower_envelope_line_store
// Convex-hull-trick line stack with pop test on add and binary-search query.
// ----------------------------------------------------------------------------
// One request is handled at a time; the slave side is ready only when the
// sequencer is idle, and a finished result waits in the output register, so
// the next request is taken while the last result is still unclaimed. All
// products run through one shared 33x33 signed multiplier with a register
// behind it, and the line stack sits in one memory with two registered read
// ports. An add makes T pop tests, where T is the number of lines popped plus
// one, less one when the pops leave a single line, and zero when fewer than
// two lines are held; each test reads two lines, forms four differences,
// runs four partial products into 82-bit cross products and compares them.
// A query makes S search steps, at most ceil(log2(lines held)); a query on
// an empty store goes straight to the result. Either one waits in the done
// state while an earlier result still sits unclaimed in the output register.
// The stack memory is not cleared after reset; only entries below the line
// count are ever read.
`default_nettype none

`include "lower_envelope_line_store_assert.svh"

module lower_envelope_line_store
  import lels_pkg::*;
#(
  parameter int MAX_LINES = MAX_LINES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Request stream
  input  wire logic                 s_axis_tvalid,
  output      logic                 s_axis_tready,
  // tdata: slope[31:0], intercept[79:32], query_x[111:80]
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
  // tuser: req_type[0]
  input  wire logic [0:0]           s_axis_tuser,
  // Result stream
  output      logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // tdata: min_value[63:0], best_index[73:64], line_count[84:74], zero pad
  output      logic [M_TDATA_W-1:0] m_axis_tdata,
  // tuser: store_empty[0], add_dropped[1]
  output      logic [1:0]           m_axis_tuser
);

  localparam int IDX_W = $clog2(MAX_LINES);
  localparam int CNT_W = $clog2(MAX_LINES + 1);

  typedef enum logic [4:0] {
    S_IDLE,
    S_ADD,
    S_PRD,
    S_PDIFF,
    S_PM0,
    S_PM1,
    S_PM2,
    S_PM3,
    S_PM4,
    S_PCMP,
    S_PUSH,
    S_QSTART,
    S_QRD,
    S_QM0,
    S_QM1,
    S_QM2,
    S_FM0,
    S_FM1,
    S_DONE
  } state_t;

  state_t state;

  // Request registers
  logic signed [SLOPE_W-1:0] req_a;
  logic signed [ICPT_W-1:0]  req_b;
  logic signed [X_W-1:0]     req_x;

  // Stack control
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W-1:0] cnt_m2;

  // Line memory with two registered read ports
  logic [LINE_W-1:0] line_mem [MAX_LINES];
  logic [LINE_W-1:0] rd0;
  logic [LINE_W-1:0] rd1;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr0;
  logic [IDX_W-1:0]  rd_addr1;
  logic              wr_en;

  logic signed [SLOPE_W-1:0] rd0_a;
  logic signed [ICPT_W-1:0]  rd0_b;
  logic signed [SLOPE_W-1:0] rd1_a;
  logic signed [ICPT_W-1:0]  rd1_b;

  // Pop test differences and accumulators
  logic signed [ICPT_W:0]  d_b1;
  logic signed [SLOPE_W:0] d_a1;
  logic signed [ICPT_W:0]  d_b2;
  logic signed [SLOPE_W:0] d_a2;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] lhs;
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W-1:0] prod_sh;
  logic                    pop_hit;

  // Shared multiplier
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;

  // Binary search
  logic [IDX_W-1:0]        lo;
  logic [IDX_W-1:0]        hi;
  logic [IDX_W:0]          mid_sum;
  logic [IDX_W-1:0]        mid;
  logic signed [ICPT_W-1:0] val_b;
  logic signed [VALUE_W-1:0] val_cur;
  logic signed [VALUE_W-1:0] v0;

  // Result under construction and output register
  logic [VALUE_W-1:0] res_min;
  logic [IDX_W-1:0]   res_best;
  logic               res_empty;
  logic               res_dropped;
  logic               out_load;
  logic [VALUE_W-1:0] out_min;
  logic [BEST_W-1:0]  out_best;
  logic [LCNT_W-1:0]  out_count;
  logic               out_empty;
  logic               out_dropped;
  logic [BEST_W+IDX_W-1:0] best_ext;
  logic [LCNT_W+CNT_W-1:0] count_ext;

  // Stream handshakes
  assign s_axis_tready = (state == S_IDLE);
  assign out_load = (state == S_DONE) && (!m_axis_tvalid || m_axis_tready);

  // Stack positions and search midpoint
  assign cnt_m1  = count - 1'b1;
  assign cnt_m2  = count - 2'd2;
  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[IDX_W:1];

  // Split read lines into fields
  assign rd0_a = rd0[SLOPE_W-1:0];
  assign rd0_b = rd0[LINE_W-1:SLOPE_W];
  assign rd1_a = rd1[SLOPE_W-1:0];
  assign rd1_b = rd1[LINE_W-1:SLOPE_W];

  // Drive memory read ports
  always_comb begin
    rd_en    = 1'b0;
    rd_addr0 = lo;
    rd_addr1 = lo;
    unique case (state)
      S_PRD: begin
        rd_en    = 1'b1;
        rd_addr0 = cnt_m2[IDX_W-1:0];
        rd_addr1 = cnt_m1[IDX_W-1:0];
      end
      S_QRD: begin
        rd_en = 1'b1;
        if (lo < hi) begin
          rd_addr0 = mid;
          rd_addr1 = mid + 1'b1;
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  assign wr_en = (state == S_PUSH) && (count < CNT_W'(MAX_LINES));

  // Line memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[count[IDX_W-1:0]] <= {req_b, req_a};
    end
    if (rd_en) begin
      rd0 <= line_mem[rd_addr0];
      rd1 <= line_mem[rd_addr1];
    end
  end

  // Select multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_PM0: begin
        mul_a = {1'b0, d_b1[31:0]};
        mul_b = d_a1;
      end
      S_PM1: begin
        mul_a = {{(MUL_W-(ICPT_W+1-32)){d_b1[ICPT_W]}}, d_b1[ICPT_W:32]};
        mul_b = d_a1;
      end
      S_PM2: begin
        mul_a = {1'b0, d_b2[31:0]};
        mul_b = d_a2;
      end
      S_PM3: begin
        mul_a = {{(MUL_W-(ICPT_W+1-32)){d_b2[ICPT_W]}}, d_b2[ICPT_W:32]};
        mul_b = d_a2;
      end
      S_QM0, S_FM0: begin
        mul_a = {rd0_a[SLOPE_W-1], rd0_a};
        mul_b = {req_x[X_W-1], req_x};
      end
      S_QM1: begin
        mul_a = {rd1_a[SLOPE_W-1], rd1_a};
        mul_b = {req_x[X_W-1], req_x};
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // Extend the product for the cross-product sums
  assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
  assign prod_sh  = prod_ext <<< 32;
  assign pop_hit  = (lhs > acc);

  // Line value at the query point
  assign val_b   = (state == S_QM2) ? rd1_b : rd0_b;
  assign val_cur = prod[VALUE_W-1:0] + {{(VALUE_W-ICPT_W){val_b[ICPT_W-1]}}, val_b};

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // Raise the result valid on a load, drop it once the transfer is taken
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      prod <= mul_a * mul_b;
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            req_a       <= s_axis_tdata[SLOPE_W-1:0];
            req_b       <= s_axis_tdata[SLOPE_W+ICPT_W-1:SLOPE_W];
            req_x       <= s_axis_tdata[S_TDATA_W-1:SLOPE_W+ICPT_W];
            res_min     <= '0;
            res_best    <= '0;
            res_empty   <= 1'b0;
            res_dropped <= 1'b0;
            state       <= (s_axis_tuser[0] == REQ_QUERY) ? S_QSTART : S_ADD;
          end
        end
        // Add: pop while the top line is hidden, then push, or drop the line when full
        S_ADD: begin
          state <= (count >= CNT_W'(2)) ? S_PRD : S_PUSH;
        end
        S_PRD: begin
          state <= S_PDIFF;
        end
        S_PDIFF: begin
          d_b1  <= {req_b[ICPT_W-1], req_b} - {rd0_b[ICPT_W-1], rd0_b};
          d_a1  <= {rd0_a[SLOPE_W-1], rd0_a} - {rd1_a[SLOPE_W-1], rd1_a};
          d_b2  <= {rd1_b[ICPT_W-1], rd1_b} - {rd0_b[ICPT_W-1], rd0_b};
          d_a2  <= {rd0_a[SLOPE_W-1], rd0_a} - {req_a[SLOPE_W-1], req_a};
          state <= S_PM0;
        end
        S_PM0: begin
          state <= S_PM1;
        end
        S_PM1: begin
          acc   <= prod_ext;
          state <= S_PM2;
        end
        S_PM2: begin
          lhs   <= acc + prod_sh;
          state <= S_PM3;
        end
        S_PM3: begin
          acc   <= prod_ext;
          state <= S_PM4;
        end
        S_PM4: begin
          acc   <= acc + prod_sh;
          state <= S_PCMP;
        end
        S_PCMP: begin
          if (pop_hit) begin
            count <= cnt_m1;
            state <= (count >= CNT_W'(3)) ? S_PRD : S_PUSH;
          end else begin
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (count < CNT_W'(MAX_LINES)) begin
            count <= count + 1'b1;
          end else begin
            res_dropped <= 1'b1;
          end
          state <= S_DONE;
        end
        // Query: binary search for the lowest line at x, or report an empty store
        S_QSTART: begin
          if (count == '0) begin
            res_min   <= EMPTY_VALUE;
            res_empty <= 1'b1;
            state     <= S_DONE;
          end else begin
            lo    <= '0;
            hi    <= cnt_m1[IDX_W-1:0];
            state <= S_QRD;
          end
        end
        S_QRD: begin
          state <= (lo < hi) ? S_QM0 : S_FM0;
        end
        S_QM0: begin
          state <= S_QM1;
        end
        S_QM1: begin
          v0    <= val_cur;
          state <= S_QM2;
        end
        S_QM2: begin
          if (v0 >= val_cur) begin
            lo <= mid + 1'b1;
          end else begin
            hi <= mid;
          end
          state <= S_QRD;
        end
        S_FM0: begin
          state <= S_FM1;
        end
        S_FM1: begin
          res_min  <= val_cur;
          res_best <= lo;
          state    <= S_DONE;
        end
        // Hand the result to the output register
        S_DONE: begin
          if (out_load) begin
            out_min       <= res_min;
            out_best      <= best_ext[BEST_W-1:0];
            out_count     <= count_ext[LCNT_W-1:0];
            out_empty     <= res_empty;
            out_dropped   <= res_dropped;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Mask positions and counts to the result field widths
  assign best_ext  = {{BEST_W{1'b0}}, res_best};
  assign count_ext = {{LCNT_W{1'b0}}, count};

  // Pack the result stream
  assign m_axis_tdata = {{(M_TDATA_W-VALUE_W-BEST_W-LCNT_W){1'b0}},
                         out_count, out_best, out_min};
  assign m_axis_tuser = {out_dropped, out_empty};

  // Checks
  `LELS_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, s_axis_tvalid && s_axis_tready,
                    state != S_IDLE, "request transfer did not start the sequencer")
  `LELS_ASSERT_NEXT(a_pop_decrements, clk, rst, (state == S_PCMP) && pop_hit,
                    (count + 1'b1) == $past(count), "pop did not drop exactly one line")
  `LELS_ASSERT_IMPLY(a_search_open, clk, rst, state == S_QM2, lo < hi,
                     "search step taken on a closed interval")
  `LELS_ASSERT_IMPLY(a_drop_when_full, clk, rst, out_load && res_dropped,
                     count == CNT_W'(MAX_LINES), "line dropped while stack had room")

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the lower envelope line store. A directed table
// covers empty queries, field extremes, ties and unordered slopes; a fill
// phase builds a full stack of non-popping lines to reach the dropped-add
// case; a random phase mixes well-formed envelope chains with noise lines and
// queries. Results are checked against an in-bench predictor or table values.
// ----------------------------------------------------------------------------
module tb;
  import lels_pkg::*;

  localparam int LINE_CAP     = MAX_LINES_DEF;
  localparam int RANDOM_ITEMS = 150;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 200;
  localparam int LIMIT        = 1000000;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] slope;
    logic signed [47:0] icpt;
    logic signed [31:0] x;
  } line_req_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic [9:0]         best;
    logic [10:0]        count;
    logic               empty;
    logic               dropped;
  } envelope_result_t;

  typedef struct packed {
    line_req_t        req;
    logic             typed;
    envelope_result_t want;
  } directed_row_t;

  logic                 clk;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic [0:0]           s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [1:0]           m_axis_tuser;

  // Envelope predictor state
  logic signed [31:0] env_slope [LINE_CAP];
  logic signed [47:0] env_icpt  [LINE_CAP];
  int                 env_count;

  envelope_result_t expected_q [$];
  directed_row_t    directed_rows [$];

  int mismatch_cnt;
  int result_cnt;
  int cycle_cnt;
  int burst_left;
  bit hold_req;

  // Chain of lines whose breakpoints fall strictly, so no line pops another
  longint chain_slope;
  longint chain_icpt;
  longint chain_x;
  int     chain_s_max;
  int     chain_g_max;

  lower_envelope_line_store #(
    .MAX_LINES(LINE_CAP)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Pop the top line when the new line makes it useless (128-bit products)
  function automatic bit pop_needed(input int b, input int t,
                                    input logic signed [31:0] na,
                                    input logic signed [47:0] nb);
    logic signed [127:0] d_icpt_n;
    logic signed [127:0] d_slope_t;
    logic signed [127:0] d_icpt_t;
    logic signed [127:0] d_slope_n;
    d_icpt_n  = nb - env_icpt[b];
    d_slope_t = env_slope[b] - env_slope[t];
    d_icpt_t  = env_icpt[t] - env_icpt[b];
    d_slope_n = env_slope[b] - na;
    return (d_icpt_n * d_slope_t) > (d_icpt_t * d_slope_n);
  endfunction

  function automatic logic signed [63:0] line_value(input int i,
                                                    input logic signed [31:0] x);
    logic signed [63:0] v;
    v = env_slope[i] * x + env_icpt[i];
    return v;
  endfunction

  function automatic envelope_result_t evaluate_request(input line_req_t r);
    envelope_result_t res;
    int lo;
    int hi;
    int mid;
    res = '0;
    if (r.kind == REQ_ADD) begin
      while (env_count >= 2 && pop_needed(env_count - 2, env_count - 1, r.slope, r.icpt))
        env_count--;
      if (env_count >= LINE_CAP) begin
        res.dropped = 1'b1;
      end else begin
        env_slope[env_count] = r.slope;
        env_icpt[env_count]  = r.icpt;
        env_count++;
      end
    end else if (env_count == 0) begin
      res.value = EMPTY_VALUE;
      res.empty = 1'b1;
    end else begin
      // Binary search; a tie moves toward the higher position
      lo = 0;
      hi = env_count - 1;
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (line_value(mid, r.x) >= line_value(mid + 1, r.x))
          lo = mid + 1;
        else
          hi = mid;
      end
      res.best  = lo[9:0];
      res.value = line_value(lo, r.x);
    end
    res.count = env_count[10:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic line_req_t make_req(input logic kind, input logic [31:0] slope,
                                         input logic [47:0] icpt, input logic [31:0] x);
    line_req_t r;
    r.kind  = kind;
    r.slope = slope;
    r.icpt  = icpt;
    r.x     = x;
    return r;
  endfunction

  task automatic add_row(input logic kind, input logic [31:0] slope,
                         input logic [47:0] icpt, input logic [31:0] x);
    directed_row_t row;
    row.req   = make_req(kind, slope, icpt, x);
    row.typed = 1'b0;
    row.want  = '0;
    directed_rows = {directed_rows, row};
  endtask

  task automatic add_checked_row(input logic kind, input logic [31:0] slope,
                                 input logic [47:0] icpt, input logic [31:0] x,
                                 input logic [63:0] value, input int best,
                                 input int count, input logic empty);
    directed_row_t row;
    row.req           = make_req(kind, slope, icpt, x);
    row.typed         = 1'b1;
    row.want          = '0;
    row.want.value    = value;
    row.want.best     = best[9:0];
    row.want.count    = count[10:0];
    row.want.empty    = empty;
    directed_rows = {directed_rows, row};
  endtask

  // Drive one request from a falling edge, hold it until the transfer
  task automatic send_item(input line_req_t r, input logic typed,
                           input envelope_result_t typed_want,
                           output envelope_result_t pred);
    envelope_result_t want;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r.x, r.icpt, r.slope};
    s_axis_tuser  <= r.kind;
    do @(posedge clk); while (!s_axis_tready);
    pred = evaluate_request(r);
    want = typed ? typed_want : pred;
    expected_q = {expected_q, want};
    @(negedge clk);
  endtask

  // Offer in bursts of random length with random gaps between them
  task automatic offer(input line_req_t r, input logic typed,
                       input envelope_result_t typed_want,
                       output envelope_result_t pred);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    send_item(r, typed, typed_want, pred);
  endtask

  // Hold the sender until every outstanding result has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (expected_q.size() != 0);
  endtask

  task automatic restart_chain(input int s_max, input int g_max);
    chain_s_max = s_max;
    chain_g_max = g_max;
    chain_slope = longint'($urandom_range(32'h7fffffff, 0));
    if ($urandom_range(0, 3) == 0)
      chain_slope = chain_slope - (longint'(1) << 30);
    chain_icpt = longint'($urandom) * 256 - (longint'(1) << 39);
    chain_x    = longint'($urandom_range(0, 2097152)) - 1048576;
  endtask

  // Extend the chain: new slope falls by s, breakpoint moves down by g
  task automatic send_chain_line();
    longint s;
    longint g;
    longint nx;
    longint ns;
    longint ni;
    envelope_result_t pred;
    s  = $urandom_range(1, chain_s_max);
    g  = $urandom_range(1, chain_g_max);
    nx = chain_x - g;
    ns = chain_slope - s;
    ni = chain_icpt + s * nx;
    if (ns < -(longint'(1) << 31) || ni >= (longint'(1) << 46) ||
        ni < -(longint'(1) << 46) || nx < -(longint'(1) << 30)) begin
      restart_chain(chain_s_max, chain_g_max);
      nx = chain_x;
      ns = chain_slope;
      ni = chain_icpt;
    end
    offer(make_req(REQ_ADD, ns[31:0], ni[47:0], $urandom), 1'b0, '0, pred);
    if (!pred.dropped) begin
      chain_slope = ns;
      chain_icpt  = ni;
      chain_x     = nx;
    end
  endtask

  task automatic send_query(input logic [31:0] x);
    envelope_result_t pred;
    offer(make_req(REQ_QUERY, $urandom, 48'({$urandom, $urandom}), x), 1'b0, '0, pred);
  endtask

  function automatic logic [31:0] pick_query_x();
    logic [31:0] x;
    case ($urandom_range(0, 5))
      0, 1:    x = 32'(chain_x + longint'($urandom_range(0, 4)) - 2);
      2:       x = 32'($urandom_range(0, 64)) - 32'd32;
      3: begin
        case ($urandom_range(0, 2))
          0:       x = 32'h8000_0000;
          1:       x = 32'h7fff_ffff;
          default: x = 32'h0;
        endcase
      end
      default: x = $urandom;
    endcase
    return x;
  endfunction

  // --------------------------------------------------------------------------
  // Result check
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch on result %0d, %s: got %0h, expected %0h",
             result_cnt, what, got, want);
    mismatch_cnt++;
  endtask

  always @(posedge clk) begin : result_check
    envelope_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transfer", m_axis_tdata[63:0], 64'h0);
      end else begin
        want = expected_q.pop_front();
        if (m_axis_tdata[63:0] !== want.value)
          report_mismatch("min_value", m_axis_tdata[63:0], want.value);
        if (m_axis_tdata[73:64] !== want.best)
          report_mismatch("best_index", 64'(m_axis_tdata[73:64]), 64'(want.best));
        if (m_axis_tdata[84:74] !== want.count)
          report_mismatch("line_count", 64'(m_axis_tdata[84:74]), 64'(want.count));
        if (m_axis_tuser[0] !== want.empty)
          report_mismatch("store_empty", 64'(m_axis_tuser[0]), 64'(want.empty));
        if (m_axis_tuser[1] !== want.dropped)
          report_mismatch("add_dropped", 64'(m_axis_tuser[1]), 64'(want.dropped));
      end
      result_cnt++;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: own stall pattern, plus a long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : receiver
    int pat_mode;
    int pat_left;
    int pat_period;
    int phase;
    int hold_cnt;
    m_axis_tready = 1'b0;
    pat_left = 0;
    phase = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
          @(negedge clk);
        hold_req = 1'b0;
      end
      if (pat_left == 0) begin
        pat_mode   = $urandom_range(0, 3);
        pat_left   = $urandom_range(20, 200);
        pat_period = $urandom_range(2, 6);
      end
      pat_left--;
      phase++;
      case (pat_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= $urandom_range(0, 1);
        2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= ((phase % pat_period) == 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    envelope_result_t pred;
    int fill_adds;
    bit fill_hold_done;
    int i;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    hold_req      = 1'b0;
    mismatch_cnt  = 0;
    result_cnt    = 0;
    burst_left    = 0;
    env_count     = 0;
    fill_hold_done = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table: empty store, extremes, ties, unordered slopes
    add_checked_row(REQ_QUERY, 32'h0, 48'h0, 32'h0, EMPTY_VALUE, 0, 0, 1'b1);
    add_checked_row(REQ_QUERY, 32'hffff_ffff, 48'hffff_ffff_ffff, 32'h8000_0000,
                    EMPTY_VALUE, 0, 0, 1'b1);
    add_checked_row(REQ_ADD, 32'd2, 48'd5, 32'hffff_ffff, 64'd0, 0, 1, 1'b0);
    add_checked_row(REQ_QUERY, 32'h0, 48'h0, 32'd3, 64'd11, 0, 1, 1'b0);
    add_checked_row(REQ_ADD, 32'h7fff_ffff, 48'h7fff_ffff_ffff, 32'h0, 64'd0, 0, 2, 1'b0);
    add_row(REQ_QUERY, 32'h0, 48'h0, 32'h8000_0000);
    add_row(REQ_QUERY, 32'h0, 48'h0, 32'h7fff_ffff);
    add_row(REQ_ADD, 32'h8000_0000, 48'h8000_0000_0000, 32'h7fff_ffff);
    add_row(REQ_QUERY, 32'h0, 48'h0, 32'h0);
    add_row(REQ_QUERY, 32'h7fff_ffff, 48'h7fff_ffff_ffff, 32'h8000_0000);
    add_row(REQ_QUERY, 32'h8000_0000, 48'h8000_0000_0000, 32'h7fff_ffff);
    add_row(REQ_ADD, 32'd0, 48'd0, 32'h0);
    add_row(REQ_ADD, 32'd1, 48'd0, 32'h0);
    add_row(REQ_ADD, 32'hffff_ffff, 48'd0, 32'h0);
    add_row(REQ_QUERY, 32'h0, 48'h0, 32'd0);
    add_row(REQ_QUERY, 32'h0, 48'h0, 32'd1);
    add_row(REQ_QUERY, 32'h0, 48'h0, 32'hffff_ffff);
    add_row(REQ_ADD, 32'hffff_fffe, 48'hffff_ffff_ffff, 32'h0);
    add_row(REQ_QUERY, 32'h0, 48'h0, 32'd12345);
    add_row(REQ_ADD, 32'h8000_0000, 48'h8000_0000_0000, 32'h0);
    add_row(REQ_ADD, 32'h7fff_ffff, 48'h7fff_ffff_ffff, 32'h0);
    add_row(REQ_QUERY, 32'h0, 48'h0, 32'h8000_0000);
    add_row(REQ_QUERY, 32'h0, 48'h0, 32'h7fff_ffff);
    foreach (directed_rows[k])
      offer(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].want, pred);
    wait_drained();

    // Fill the stack with a non-popping chain until adds are dropped
    restart_chain(1000, 100);
    fill_adds = 0;
    while (env_count < LINE_CAP && fill_adds < 4 * LINE_CAP) begin
      send_chain_line();
      fill_adds++;
      if ($urandom_range(0, 15) == 0)
        send_query(pick_query_x());
      // Long receiver hold-off while the sender keeps offering
      if (!fill_hold_done && env_count >= LINE_CAP / 2) begin
        hold_req = 1'b1;
        fill_hold_done = 1'b1;
      end
    end
    for (i = 0; i < 3; i++)
      send_chain_line();
    send_query(32'h8000_0000);
    send_query(32'h7fff_ffff);
    send_query(32'h0);
    send_query(32'(chain_x));
    wait_drained();

    // Random part: chains with random content, queries and some noise lines
    restart_chain(65536, 1024);
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2)
        hold_req = 1'b1;
      if (i == RANDOM_ITEMS / 3 || i == (2 * RANDOM_ITEMS) / 3)
        wait_drained();
      case ($urandom_range(0, 99)) inside
        [0:44]: begin
          if ($urandom_range(0, 39) == 0) begin
            case ($urandom_range(0, 2))
              0:       restart_chain(16, 4);
              1:       restart_chain(1024, 256);
              default: restart_chain(65536, 1024);
            endcase
          end
          send_chain_line();
        end
        [45:79]: send_query(pick_query_x());
        [80:91]:
          offer(make_req(REQ_ADD, $urandom, 48'({$urandom, $urandom}), $urandom),
                1'b0, '0, pred);
        default: send_query($urandom);
      endcase
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/lels_pkg.sv
hw/rtl/lower_envelope_line_store.sv
dv/tb.sv
